>>> rtl/imtok_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// imtok_pkg
// Types, constants and helpers shared by the immediate tokenizer modules.
// ----------------------------------------------------------------------------
package imtok_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;
	localparam int CHAR_W     = 7;
	localparam int SHIFT_W    = 5;
	localparam int QUEUE_DEPTH_DEF = 4;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_COMMENT    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_POINT      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SEPARATOR  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DATA_START = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_LOAD_CODE  = 3'd4;

	localparam logic [CHAR_W-1:0] RST_COMMENT    = 7'd92;
	localparam logic [CHAR_W-1:0] RST_POINT      = 7'd46;
	localparam logic [CHAR_W-1:0] RST_SEPARATOR  = 7'd44;
	localparam logic [CHAR_W-1:0] RST_DATA_START = 7'd36;
	localparam logic [7:0]        RST_LOAD_CODE  = 8'd1;

	localparam logic [CHAR_W-1:0] CH_SPACE   = 7'd32;
	localparam logic [CHAR_W-1:0] CH_NEWLINE = 7'd10;

	localparam logic [SHIFT_W-1:0] INT_SHIFT  = 5'd16;
	localparam logic [SHIFT_W-1:0] FRAC_SHIFT = 5'd12;
	localparam logic [SHIFT_W-1:0] DIGIT_STEP = 5'd4;

	typedef enum logic [1:0] {
		PH_NONE,
		PH_INT,
		PH_FRAC
	} num_phase_t;

	typedef enum logic [1:0] {
		TAIL_NONE,
		TAIL_CHAR,
		TAIL_TERM1,
		TAIL_TERM2
	} tail_kind_t;

	typedef struct packed {
		logic [7:0] source_char;
		logic       end_of_source;
	} src_item_t;

	typedef struct packed {
		logic [7:0]  code_byte;
		logic [31:0] hint_word;
		logic        run_last;
	} code_entry_t;

	// one queued command: optional load entry, then a tail
	typedef struct packed {
		logic        flush;
		logic [7:0]  load_code;
		logic [31:0] value;
		tail_kind_t  tail;
		logic [7:0]  chr;
	} tok_cmd_t;

	// {valid, value} of an uppercase hex digit
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		r = '0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end
		return r;
	endfunction

endpackage
`default_nettype wire

>>> rtl/imtok_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// imtok_front
// Accepts source bytes, tracks number/comment/data state, builds commands.
// ----------------------------------------------------------------------------
module imtok_front (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               cfg_we,
	input  wire [imtok_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  wire [imtok_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  wire                               in_fire,
	input  imtok_pkg::src_item_t              in_item,
	output logic                              push,
	output imtok_pkg::tok_cmd_t               cmd
);
	import imtok_pkg::*;

	logic [CHAR_W-1:0]  comment_q, point_q, sep_q, dstart_q;
	logic [7:0]         load_code_q;
	num_phase_t         phase_q, phase_d;
	logic [31:0]        accum_q, accum_d;
	logic [SHIFT_W-1:0] shift_q, shift_d;
	logic               comment_mode_q, comment_mode_d;
	logic               data_q, data_d;

	logic [7:0]         ch;
	logic [CHAR_W-1:0]  c7;
	logic               eos, skip, is_point, is_num, is_nl, has_num;
	logic [4:0]         hex;
	logic [31:0]        acc_base, acc_rot;
	logic [SHIFT_W-1:0] dig_shift;

	assign ch       = in_item.source_char;
	assign eos      = in_item.end_of_source;
	assign c7       = ch[CHAR_W-1:0];
	assign skip     = data_q || (ch == 8'd0) || ch[7];
	assign hex      = hex_decode(ch);
	assign is_point = (c7 == point_q);
	assign is_num   = is_point || hex[4];
	assign is_nl    = (c7 == CH_NEWLINE);
	assign has_num  = (phase_q != PH_NONE);

	assign acc_base  = has_num ? accum_q : 32'd0;
	assign acc_rot   = (phase_q == PH_FRAC) ? acc_base : {acc_base[27:0], acc_base[31:28]};
	assign dig_shift = has_num ? shift_q : INT_SHIFT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			comment_q   <= RST_COMMENT;
			point_q     <= RST_POINT;
			sep_q       <= RST_SEPARATOR;
			dstart_q    <= RST_DATA_START;
			load_code_q <= RST_LOAD_CODE;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_COMMENT:    comment_q   <= cfg_wdata[CHAR_W-1:0];
				CFG_POINT:      point_q     <= cfg_wdata[CHAR_W-1:0];
				CFG_SEPARATOR:  sep_q       <= cfg_wdata[CHAR_W-1:0];
				CFG_DATA_START: dstart_q    <= cfg_wdata[CHAR_W-1:0];
				CFG_LOAD_CODE:  load_code_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_NONE;
			accum_q        <= '0;
			shift_q        <= INT_SHIFT;
			comment_mode_q <= 1'b0;
			data_q         <= 1'b0;
		end else begin
			phase_q        <= phase_d;
			accum_q        <= accum_d;
			shift_q        <= shift_d;
			comment_mode_q <= comment_mode_d;
			data_q         <= data_d;
		end
	end

	// next state
	always_comb begin
		phase_d        = phase_q;
		accum_d        = accum_q;
		shift_d        = shift_q;
		comment_mode_d = comment_mode_q;
		data_d         = data_q;
		if (in_fire) begin
			if (eos) begin
				phase_d        = PH_NONE;
				accum_d        = '0;
				shift_d        = INT_SHIFT;
				comment_mode_d = 1'b0;
				data_d         = 1'b0;
			end else if (skip) begin
			end else if (comment_mode_q) begin
				if (is_nl) begin
					comment_mode_d = 1'b0;
				end
			end else if (is_num) begin
				if (is_point) begin
					if (phase_q != PH_INT) begin
						accum_d = '0;
					end
					phase_d = PH_FRAC;
					shift_d = FRAC_SHIFT;
				end else begin
					accum_d = acc_rot | (32'(hex[3:0]) << dig_shift);
					if (phase_q == PH_FRAC) begin
						shift_d = shift_q - DIGIT_STEP;
					end else begin
						shift_d = dig_shift;
					end
					if (phase_q == PH_NONE) begin
						phase_d = PH_INT;
					end
				end
			end else begin
				phase_d = PH_NONE;
				if (c7 == comment_q) begin
					comment_mode_d = 1'b1;
				end else if (c7 == sep_q || c7 == CH_SPACE || is_nl) begin
				end else if (c7 == dstart_q) begin
					data_d = 1'b1;
				end
			end
		end
	end

	// command out
	always_comb begin
		cmd.flush     = 1'b0;
		cmd.load_code = load_code_q;
		cmd.value     = accum_q;
		cmd.tail      = TAIL_NONE;
		cmd.chr       = ch;
		if (eos) begin
			if (!data_q) begin
				cmd.flush = has_num;
				cmd.tail  = TAIL_TERM1;
			end
		end else if (skip || comment_mode_q) begin
		end else if (is_num) begin
			cmd.flush = is_point && (phase_q == PH_FRAC);
		end else begin
			cmd.flush = has_num;
			if (c7 == comment_q) begin
			end else if (c7 == sep_q || c7 == CH_SPACE || is_nl) begin
			end else if (c7 == dstart_q) begin
				cmd.tail = TAIL_TERM2;
			end else begin
				cmd.tail = TAIL_CHAR;
			end
		end
	end

	assign push = in_fire && (cmd.flush || (cmd.tail != TAIL_NONE));

endmodule
`default_nettype wire

>>> rtl/imtok_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// imtok_fifo
// Short command queue between front and back.
// ----------------------------------------------------------------------------
module imtok_fifo #(
	parameter int DEPTH = imtok_pkg::QUEUE_DEPTH_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push,
	input  imtok_pkg::tok_cmd_t  push_data,
	input  wire                  pop,
	output imtok_pkg::tok_cmd_t  head,
	output logic                 empty,
	output logic                 full
);
	import imtok_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	tok_cmd_t           mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign head  = mem_q[rd_ptr_q];
	assign empty = (count_q == '0);
	assign full  = (count_q == CNT_W'(DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

>>> rtl/imtok_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// imtok_back
// Expands each queued command into one to three code entries.
// ----------------------------------------------------------------------------
module imtok_back (
	input  wire                     clk,
	input  wire                     arst_n,
	input  imtok_pkg::tok_cmd_t     head,
	input  wire                     empty,
	output logic                    pop,
	output logic                    out_valid,
	input  wire                     out_stall,
	output imtok_pkg::code_entry_t  out_item
);
	import imtok_pkg::*;

	logic        out_valid_q;
	code_entry_t out_item_q;
	logic [1:0]  idx_q;
	logic [1:0]  tail_cnt, total;
	logic        load_en, take, last;
	code_entry_t entry;

	always_comb begin
		unique case (head.tail)
			TAIL_NONE:  tail_cnt = 2'd0;
			TAIL_CHAR:  tail_cnt = 2'd1;
			TAIL_TERM1: tail_cnt = 2'd1;
			TAIL_TERM2: tail_cnt = 2'd2;
			default:    tail_cnt = 2'd0;
		endcase
	end

	assign total = tail_cnt + {1'b0, head.flush};
	assign last  = (idx_q == total - 2'd1);

	always_comb begin
		entry.run_last = last;
		if (head.flush && idx_q == 2'd0) begin
			entry.code_byte = head.load_code;
			entry.hint_word = head.value;
		end else begin
			entry.code_byte = (head.tail == TAIL_CHAR) ? head.chr : 8'd0;
			entry.hint_word = '0;
		end
	end

	assign load_en = !out_valid_q || !out_stall;
	assign take    = load_en && !empty;
	assign pop     = take && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (load_en) begin
				out_valid_q <= !empty;
			end
			if (take) begin
				idx_q <= last ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_item_q <= entry;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule
`default_nettype wire

>>> rtl/immediate_tokenizer_core.sv
// A byte's command is registered in the queue and each entry in the output register.
// Throughput: one source byte per cycle unless in_stall; results leave one per cycle
// unless out_stall, so a byte's two or three entries hold the output till all leave.
// The command queue (QUEUE_DEPTH entries) absorbs those bursts before in_stall rises.
// Reset: arst_n clears number, comment and data state, empties the queue and
// restores all character registers to their defaults.
`default_nettype none
// ----------------------------------------------------------------------------
// immediate_tokenizer_core
// Source byte tokenizer producing opcode / 16.16 immediate code entries.
// ----------------------------------------------------------------------------
module immediate_tokenizer_core #(
	parameter int QUEUE_DEPTH = imtok_pkg::QUEUE_DEPTH_DEF
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             cfg_we,
	input  wire [imtok_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  wire [imtok_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  wire                             in_valid,
	output logic                            in_stall,
	input  imtok_pkg::src_item_t            in_item,
	output logic                            out_valid,
	input  wire                             out_stall,
	output imtok_pkg::code_entry_t          out_item
);
	import imtok_pkg::*;

	logic     in_fire, q_push, q_pop, q_empty, q_full;
	tok_cmd_t q_in, q_head;

	assign in_stall = q_full;
	assign in_fire  = in_valid && !q_full;

	imtok_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.in_fire   (in_fire),
		.in_item   (in_item),
		.push      (q_push),
		.cmd       (q_in)
	);

	imtok_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.pop       (q_pop),
		.head      (q_head),
		.empty     (q_empty),
		.full      (q_full)
	);

	imtok_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (q_head),
		.empty     (q_empty),
		.pop       (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("command pushed into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("command popped from empty queue");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_item.run_last) |=> out_valid)
		else $error("entry run broken before its last beat");
`endif

endmodule
`default_nettype wire
